>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the sharpen filter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every rising edge outside reset.
`define SHP_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition must never be true at a rising edge outside reset.
`define SHP_ASSERT_NEVER(name, clk, rst, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define SHP_ASSERT(name, clk, rst, prop, msg)
`define SHP_ASSERT_NEVER(name, clk, rst, cond, msg)

`endif

`endif

>>> rtl/core/shp_pkg.sv
// ----------------------------------------------------------------------------
// shp_pkg
// Types and constants shared by the 3x3 sharpen stream modules.
// ----------------------------------------------------------------------------
package shp_pkg;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int WIDTH_W   = 12;
  localparam int HEIGHT_W  = 16;
  localparam int CHAN_W    = 3;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;
  localparam logic [CHAN_W-1:0]   CHAN_RESET   = 3'd1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_CHANNEL_COUNT = 2'd2
  } cfg_reg_t;

  // Per-sample control decided at acceptance
  typedef struct packed {
    logic border;      // result pixel lies on the frame border
    logic two_rows;    // sample of the last row: also emit that row's zero
    logic frame_end;   // last sample of the frame
    logic bank;        // line store roles at acceptance
  } shp_item_t;

endpackage

>>> rtl/core/shp_line_store.sv
// ----------------------------------------------------------------------------
// shp_line_store
// One line buffer: single write port, two registered read ports.
// ----------------------------------------------------------------------------
module shp_line_store #(
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [shp_pkg::PIX_W-1:0] wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [shp_pkg::PIX_W-1:0] rdata_a,
  output logic [shp_pkg::PIX_W-1:0] rdata_b
);
  import shp_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];

  // Reads return the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

>>> rtl/core/shp_scan_ctrl.sv
// ----------------------------------------------------------------------------
// shp_scan_ctrl
// Configuration registers, row/column scan counters and line store control.
// ----------------------------------------------------------------------------
module shp_scan_ctrl #(
  parameter int MAX_WIDTH    = 2048,
  parameter int MAX_CHANNELS = 4
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [shp_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [shp_pkg::CFG_W-1:0]              cfg_wdata,
  input  logic                                   accept,
  output logic                                   has_out,
  output shp_pkg::shp_item_t                     item,
  output logic [$clog2(MAX_CHANNELS+1)-1:0]      ch_eff,
  output logic                                   we_old,
  output logic                                   we_new,
  output logic                                   rd_en,
  output logic [$clog2(MAX_WIDTH*MAX_CHANNELS)-1:0] addr_c,
  output logic [$clog2(MAX_WIDTH*MAX_CHANNELS)-1:0] addr_r
);
  import shp_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_CHANNELS;
  localparam int AW    = $clog2(DEPTH);
  localparam int LEN_W = $clog2(DEPTH + 1);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int CH_W  = $clog2(MAX_CHANNELS + 1);

  logic [WIDTH_W-1:0]  image_width;
  logic [HEIGHT_W-1:0] image_height;
  logic [CHAN_W-1:0]   channel_count;

  logic [AW-1:0]       col;
  logic [HEIGHT_W-1:0] row;
  logic                bank;

  logic [WW-1:0]       w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic [LEN_W-1:0]    len;
  logic [LEN_W-1:0]    ch_len;
  logic [AW-1:0]       col_at;
  logic [HEIGHT_W-1:0] row_at;
  logic [LEN_W-1:0]    col_inc;
  logic [HEIGHT_W:0]   row_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= WIDTH_RESET;
      image_height  <= HEIGHT_RESET;
      channel_count <= CHAN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:   image_width   <= cfg_wdata[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT:  image_height  <= cfg_wdata[HEIGHT_W-1:0];
        REG_CHANNEL_COUNT: channel_count <= cfg_wdata[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the registers to the supported geometry
  always_comb begin
    if (image_width < WIDTH_W'(3)) begin
      w_eff = WW'(3);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(image_width);
    end
    if (channel_count == '0) begin
      ch_eff = CH_W'(1);
    end else if (32'(channel_count) > 32'(MAX_CHANNELS)) begin
      ch_eff = CH_W'(MAX_CHANNELS);
    end else begin
      ch_eff = CH_W'(channel_count);
    end
    h_eff  = (image_height < HEIGHT_W'(3)) ? HEIGHT_W'(3) : image_height;
    len    = LEN_W'(w_eff) * LEN_W'(ch_eff);
    ch_len = LEN_W'(ch_eff);
  end

  // Restart counters that lie past a shrunken geometry
  always_comb begin
    col_at  = (LEN_W'(col) >= len) ? '0 : col;
    row_at  = (row >= h_eff) ? '0 : row;
    col_inc = LEN_W'(col_at) + LEN_W'(1);
    row_inc = {1'b0, row_at} + (HEIGHT_W+1)'(1);

    has_out        = (row_at != '0);
    item.border    = (row_at == HEIGHT_W'(1)) || (LEN_W'(col_at) < ch_len) ||
                     (LEN_W'(col_at) >= len - ch_len);
    item.two_rows  = (row_at == h_eff - HEIGHT_W'(1));
    item.frame_end = item.two_rows && (LEN_W'(col_at) == len - LEN_W'(1));
    item.bank      = bank;

    // Incoming row overwrites the store that holds two rows up
    we_old = accept && !bank;
    we_new = accept && bank;
    rd_en  = accept && has_out;
    addr_c = col_at;
    addr_r = AW'(col_at + AW'(ch_eff));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      bank <= 1'b0;
    end else if (accept) begin
      if (col_inc >= len) begin
        col  <= '0;
        bank <= !bank;
        row  <= (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[HEIGHT_W-1:0];
      end else begin
        col <= AW'(col_inc);
        row <= row_at;
      end
    end
  end

endmodule

>>> rtl/core/shp_filter_out.sv
// ----------------------------------------------------------------------------
// shp_filter_out
// Kernel stage and output register: forms the 3x3 sharpen result from the
// line store reads and emits one or two results per sample.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module shp_filter_out #(
  parameter int MAX_CHANNELS = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               load,
  input  shp_pkg::shp_item_t                 item,
  input  logic [shp_pkg::PIX_W-1:0]          sample,
  input  logic [$clog2(MAX_CHANNELS+1)-1:0]  ch_eff,
  input  logic [shp_pkg::PIX_W-1:0]          old_a,
  input  logic [shp_pkg::PIX_W-1:0]          old_b,
  input  logic [shp_pkg::PIX_W-1:0]          new_a,
  input  logic [shp_pkg::PIX_W-1:0]          new_b,
  output logic                               take_ready,
  output logic                               o_valid,
  input  logic                               o_ready,
  output logic [shp_pkg::PIX_W-1:0]          o_value,
  output logic                               o_last,
  output logic                               o_eof
);
  import shp_pkg::*;

  localparam int CH_W = $clog2(MAX_CHANNELS + 1);
  localparam int HI_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic             s1_v;
  logic             s1_phase;
  shp_item_t        s1_item;
  logic [PIX_W-1:0] s1_sample;
  logic [PIX_W-1:0] hist [MAX_CHANNELS];

  logic [PIX_W-1:0] cen;
  logic [PIX_W-1:0] right;
  logic [PIX_W-1:0] up;
  logic [PIX_W-1:0] left;
  logic [11:0]      sum5;
  logic [11:0]      subs;
  logic [11:0]      diff;
  logic [PIX_W-1:0] first_value;
  logic             o_free;
  logic             emit;
  logic             leave;

  always_comb begin
    cen   = s1_item.bank ? old_a : new_a;
    right = s1_item.bank ? old_b : new_b;
    up    = s1_item.bank ? new_a : old_a;
    left  = hist[HI_W'(ch_eff - CH_W'(1))];

    sum5 = {2'b00, cen, 2'b00} + {4'b0000, cen};
    subs = {4'b0000, left} + {4'b0000, right} + {4'b0000, up} + {4'b0000, s1_sample};
    diff = sum5 - subs;

    if (s1_item.border || (sum5 < subs)) begin
      first_value = '0;
    end else if (diff > 12'd255) begin
      first_value = 8'd255;
    end else begin
      first_value = diff[PIX_W-1:0];
    end

    o_free     = !o_valid || o_ready;
    emit       = s1_v && o_free;
    leave      = emit && (s1_phase || !s1_item.two_rows);
    take_ready = !s1_v || leave;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v     <= 1'b0;
      s1_phase <= 1'b0;
    end else if (load) begin
      s1_v     <= 1'b1;
      s1_phase <= 1'b0;
    end else if (leave) begin
      s1_v     <= 1'b0;
      s1_phase <= 1'b0;
    end else if (emit) begin
      s1_phase <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_item   <= item;
      s1_sample <= sample;
    end
  end

  // Centre taps of earlier samples supply the left neighbor
  always_ff @(posedge clk) begin
    if (leave) begin
      hist[0] <= cen;
      for (int i = 1; i < MAX_CHANNELS; i++) begin
        hist[i] <= hist[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (emit) begin
      o_valid <= 1'b1;
    end else if (o_ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_value <= s1_phase ? '0 : first_value;
      o_last  <= s1_phase || !s1_item.two_rows;
      o_eof   <= (s1_phase || !s1_item.two_rows) && s1_item.frame_end;
    end
  end

  `SHP_ASSERT_NEVER(a_no_overrun, clk, rst, load && s1_v && !leave, "kernel stage overwritten")
  `SHP_ASSERT(a_phase_two, clk, rst, s1_v && s1_phase |-> s1_item.two_rows, "stray second result")
  `SHP_ASSERT(a_phase_after_emit, clk, rst, $rose(s1_phase) |-> $past(emit), "phase without emit")
  `SHP_ASSERT(a_drain, clk, rst, leave && !load |=> !s1_v, "kernel stage did not drain")
  `SHP_ASSERT(a_eof_last, clk, rst, o_valid && o_eof |-> o_last, "frame end not on last of run")

endmodule

>>> rtl/core/sharpen_3x3_stream_top.sv
// ----------------------------------------------------------------------------
// sharpen_3x3_stream_top
// Streaming 3x3 sharpen over interleaved 8-bit channel samples.
//
//   Channel   Direction  Fields
//   s_*       in         tdata[7:0] sample
//   m_*       out        tdata[7:0] out_value, tlast last_of_run,
//                        tuser end_of_frame
//   cfg_*     in         index 0 image_width, 1 image_height, 2 channel_count
//
// One sample per clock while the kernel stage can take it; the first result
// passes the kernel stage and then the result register. Samples of the last
// row emit two results and hold the input until both have been emitted.
// Line stores need no clearing pass after reset; rst clears counters,
// configuration and valid flags.
// Output stalls back-pressure the input only once the kernel stage is full.
// ----------------------------------------------------------------------------
module sharpen_3x3_stream_top #(
  parameter int MAX_WIDTH    = 2048,
  parameter int MAX_CHANNELS = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [shp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [shp_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] sample
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,   // [7:0] out_value
  output logic                          m_tlast,
  output logic                          m_tuser    // [0] end_of_frame
);
  import shp_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_CHANNELS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CH_W  = $clog2(MAX_CHANNELS + 1);

  logic             accept;
  logic             has_out;
  logic             take_ready;
  shp_item_t        item;
  logic [CH_W-1:0]  ch_eff;
  logic             we_old;
  logic             we_new;
  logic             rd_en;
  logic [AW-1:0]    addr_c;
  logic [AW-1:0]    addr_r;
  logic [PIX_W-1:0] old_a;
  logic [PIX_W-1:0] old_b;
  logic [PIX_W-1:0] new_a;
  logic [PIX_W-1:0] new_b;

  // First-row samples only fill the line store
  assign s_tready = take_ready || !has_out;
  assign accept   = s_tvalid && s_tready;

  shp_scan_ctrl #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .has_out   (has_out),
    .item      (item),
    .ch_eff    (ch_eff),
    .we_old    (we_old),
    .we_new    (we_new),
    .rd_en     (rd_en),
    .addr_c    (addr_c),
    .addr_r    (addr_r)
  );

  shp_line_store #(
    .DEPTH (DEPTH)
  ) u_old_line (
    .clk     (clk),
    .we      (we_old),
    .waddr   (addr_c),
    .wdata   (s_tdata),
    .re      (rd_en),
    .raddr_a (addr_c),
    .raddr_b (addr_r),
    .rdata_a (old_a),
    .rdata_b (old_b)
  );

  shp_line_store #(
    .DEPTH (DEPTH)
  ) u_new_line (
    .clk     (clk),
    .we      (we_new),
    .waddr   (addr_c),
    .wdata   (s_tdata),
    .re      (rd_en),
    .raddr_a (addr_c),
    .raddr_b (addr_r),
    .rdata_a (new_a),
    .rdata_b (new_b)
  );

  shp_filter_out #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_filter (
    .clk        (clk),
    .rst        (rst),
    .load       (accept && has_out),
    .item       (item),
    .sample     (s_tdata),
    .ch_eff     (ch_eff),
    .old_a      (old_a),
    .old_b      (old_b),
    .new_a      (new_a),
    .new_b      (new_b),
    .take_ready (take_ready),
    .o_valid    (m_tvalid),
    .o_ready    (m_tready),
    .o_value    (m_tdata),
    .o_last     (m_tlast),
    .o_eof      (m_tuser)
  );

endmodule

>>> tb/sv/tb_sharpen_3x3_stream_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sharpen_3x3_stream_top
// Self-checking bench for the streaming 3x3 sharpen filter.
//
// Drives channel samples in raster order and predicts every result with a
// line-store model kept in a scoreboard. The run opens with the reset
// geometry and a column restart. Short hand-built frames follow, then a
// height restart and one frame with saturated width and channel registers.
// Random geometries with random idling on both streams, a long output stall
// and input pauses close the run.
// ----------------------------------------------------------------------------
module tb_sharpen_3x3_stream_top;
  import shp_pkg::*;

  localparam int  LONG_HOLD   = 300;
  localparam int  SETTLE      = 16;
  localparam int  RANDOM_GOAL = 1000;
  localparam real TIMEOUT_NS  = 24_000_000.0;

  class sharpen_scoreboard;
    typedef struct {
      logic [7:0] value;
      logic       last;
      logic       eof;
    } pixel_result_t;

    pixel_result_t   result_q [$];
    logic [11:0]     width_q;
    logic [15:0]     height_q;
    logic [2:0]      chans_q;
    logic [7:0]      line_a [0:8191];
    logic [7:0]      line_b [0:8191];
    int unsigned     col;
    int unsigned     row;
    bit              bank;
    int              errors;
    int              samples_seen;
    int              results_seen;

    function new();
      width_q      = WIDTH_RESET;
      height_q     = HEIGHT_RESET;
      chans_q      = CHAN_RESET;
      col          = 0;
      row          = 0;
      bank         = 1'b0;
      errors       = 0;
      samples_seen = 0;
      results_seen = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [15:0] v);
      case (idx)
        REG_IMAGE_WIDTH:   width_q  = v[11:0];
        REG_IMAGE_HEIGHT:  height_q = v[15:0];
        REG_CHANNEL_COUNT: chans_q  = v[2:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_chans();
      if (chans_q < 1) return 1;
      if (chans_q > 4) return 4;
      return chans_q;
    endfunction

    function int unsigned row_len();
      int unsigned w;
      w = width_q;
      if (w < 3) w = 3;
      if (w > 2048) w = 2048;
      return w * eff_chans();
    endfunction

    function int unsigned eff_height();
      return (height_q < 3) ? 3 : height_q;
    endfunction

    function int unsigned frame_samples();
      return row_len() * eff_height();
    endfunction

    function int pending();
      return result_q.size();
    endfunction

    function void note_sample(logic [7:0] s);
      int unsigned   len;
      int unsigned   h;
      int unsigned   ch;
      int unsigned   c;
      int unsigned   r;
      int            acc;
      logic [7:0]    up_l;
      logic [7:0]    up_c;
      logic [7:0]    up_r;
      logic [7:0]    two;
      bit            border;
      pixel_result_t res;
      len = row_len();
      h   = eff_height();
      ch  = eff_chans();
      // restart counters that lie beyond a changed geometry
      if (col >= len) col = 0;
      if (row >= h) row = 0;
      c = col;
      r = row;
      if (r >= 1) begin
        res.value = 8'd0;
        border = (r == 1) || (c < ch) || (c >= len - ch);
        if (!border) begin
          up_c = bank ? line_a[c]      : line_b[c];
          up_l = bank ? line_a[c - ch] : line_b[c - ch];
          up_r = bank ? line_a[c + ch] : line_b[c + ch];
          two  = bank ? line_b[c]      : line_a[c];
          acc  = 5 * int'(up_c) - int'(up_l) - int'(up_r) - int'(two) - int'(s);
          if (acc < 0) res.value = 8'd0;
          else if (acc > 255) res.value = 8'd255;
          else res.value = acc[7:0];
        end
        res.last = (r != h - 1);
        res.eof  = 1'b0;
        result_q.push_back(res);
        // last row: append that row's own zero result
        if (r == h - 1) begin
          res.value = 8'd0;
          res.last  = 1'b1;
          res.eof   = (c == len - 1);
          result_q.push_back(res);
        end
      end
      if (bank) line_b[c] = s;
      else line_a[c] = s;
      c++;
      if (c >= len) begin
        c = 0;
        bank = !bank;
        r++;
        if (r >= h) r = 0;
      end
      col = c;
      row = r;
      samples_seen++;
    endfunction

    task report(string what);
      errors++;
      $display("MISMATCH: %s", what);
    endtask

    task check_result(logic [7:0] d, logic l, logic u);
      pixel_result_t e;
      if (result_q.size() == 0) begin
        report($sformatf("unexpected result value=%0d last=%b eof=%b", d, l, u));
      end else begin
        e = result_q.pop_front();
        results_seen++;
        if (d !== e.value || l !== e.last || u !== e.eof)
          report($sformatf("result %0d: got value=%0d last=%b eof=%b, want %0d/%b/%b",
                           results_seen, d, l, u, e.value, e.last, e.eof));
      end
    endtask
  endclass

  logic              clk;
  logic              rst;
  logic              cfg_we;
  cfg_reg_t          cfg_index;
  logic [CFG_W-1:0]  cfg_wdata;
  logic              s_tvalid;
  logic              s_tready;
  logic [7:0]        s_tdata;   // [7:0] sample
  logic              m_tvalid;
  logic              m_tready;
  logic [7:0]        m_tdata;   // [7:0] out_value
  logic              m_tlast;
  logic              m_tuser;   // [0] end_of_frame

  sharpen_scoreboard sb;
  int                src_gap_max;
  int                sink_gap_max;
  bit                hold_req;

  sharpen_3x3_stream_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Returns right after the accepting edge; the caller releases valid.
  task automatic push_sample(input logic [7:0] v);
    int gap;
    gap = $urandom_range(0, src_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
    sb.note_sample(v);
  endtask

  task automatic release_input();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic drain();
    release_input();
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_config(input logic [15:0] w, input logic [15:0] h,
                              input logic [15:0] ch);
    cfg_reg_t   regs [3];
    logic [15:0] vals [3];
    regs[0] = REG_IMAGE_WIDTH;
    regs[1] = REG_IMAGE_HEIGHT;
    regs[2] = REG_CHANNEL_COUNT;
    vals[0] = w;
    vals[1] = h;
    vals[2] = ch;
    for (int i = 0; i < 3; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_wdata <= vals[i];
      sb.set_reg(regs[i], vals[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_config();
    logic [15:0] w;
    logic [15:0] h;
    logic [15:0] ch;
    w  = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 2))
                                      : 16'($urandom_range(3, 12));
    h  = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 2))
                                      : 16'($urandom_range(3, 6));
    ch = 16'($urandom_range(0, 7));
    write_config(w, h, ch);
  endtask

  // One frame of samples; biased frames lean on 0 and 255 to hit the clamps.
  task automatic random_frame(input int pause_at, input bit biased);
    int          n;
    logic [7:0]  v;
    n = sb.frame_samples();
    for (int k = 0; k < n; k++) begin
      if (k == pause_at) begin
        release_input();
        while (sb.pending() != 0) @(negedge clk);
      end
      if (biased && $urandom_range(0, 1) == 1) v = ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd0;
      else v = 8'($urandom_range(0, 255));
      push_sample(v);
    end
  endtask

  // Result receiver: random hold-off per transaction, long hold on request.
  initial begin : result_sink
    int gap;
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      gap = $urandom_range(0, sink_gap_max);
      if (hold_req) begin
        hold_req = 1'b0;
        gap += LONG_HOLD;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_result(m_tdata, m_tlast, m_tuser);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    logic [7:0] pattern [$];
    int         phase;
    int         frames;
    int         n;
    int         pause;
    int         random_items;
    sb           = new();
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = REG_IMAGE_WIDTH;
    cfg_wdata    = '0;
    s_tvalid     = 1'b0;
    s_tdata      = 8'd0;
    src_gap_max  = 4;
    sink_gap_max = 4;
    hold_req     = 1'b0;
    random_items = 0;
    phase        = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // reset geometry: finish row 0 at 640 and step three samples into row 1
    repeat (643) push_sample(8'($urandom_range(0, 255)));
    drain();
    // column 3 now lies past the row: row 1 restarts at column 0
    write_config(3, 3, 1);
    repeat (6) push_sample(8'($urandom_range(0, 255)));

    // lone bright centre: clamps high
    pattern = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0};
    foreach (pattern[i]) push_sample(pattern[i]);
    drain();
    // dark centre clamps low, bright centre beside it clamps high
    write_config(4, 3, 1);
    pattern = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd0,
                8'd0, 8'd0, 8'd0, 8'd255};
    foreach (pattern[i]) push_sample(pattern[i]);
    drain();

    // tallest frame cut short at a row start: height change restarts the frame
    write_config(3, 16'hFFFF, 1);
    repeat (15) push_sample(8'($urandom_range(0, 255)));
    drain();
    write_config(3, 4, 1);
    random_frame(-1, 1'b0);
    drain();

    // width register below range and channel register above range
    src_gap_max  = 0;
    sink_gap_max = 0;
    write_config(16'h0002, 3, 16'h0007);
    random_frame(-1, 1'b1);

    while (random_items < RANDOM_GOAL) begin
      drain();
      src_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 4;
      sink_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
      if (phase == 1 || phase == 6) begin
        // enough results to back the block up during the long stall
        write_config(8, 5, 4);
        hold_req = 1'b1;
      end else begin
        random_config();
      end
      frames = $urandom_range(1, 2);
      repeat (frames) begin
        n     = sb.frame_samples();
        pause = (phase == 0 || $urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : -1;
        random_frame(pause, 1'($urandom_range(0, 1)));
        random_items += n;
      end
      phase++;
    end
    drain();

    $display("Checked %0d results from %0d samples: reset geometry, restarts,",
             sb.results_seen, sb.samples_seen);
    $display("saturated registers and %0d random geometries with idling, a long stall and pauses.",
             phase);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Timeout with %0d results outstanding", sb.pending());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/shp_pkg.sv
rtl/core/shp_line_store.sv
rtl/core/shp_scan_ctrl.sv
rtl/core/shp_filter_out.sv
rtl/core/sharpen_3x3_stream_top.sv
tb/sv/tb_sharpen_3x3_stream_top.sv
